[rtl/core/lpfp_pkg.sv]
// Shared constants and types for the length-prefixed frame parser.
package lpfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // parser phases
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_PROTOCOL = 2'd1;
    localparam logic [1:0] PH_PAYLOAD  = 2'd2;
    localparam logic [1:0] PH_HALTED   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [1:0] KIND_ZERO     = 2'd3;

    // register indexes (word address)
    localparam logic [1:0] REG_MAX_LENGTH     = 2'd0;
    localparam logic [1:0] REG_LIMIT_ENABLE   = 2'd1;
    localparam logic [1:0] REG_DESCRAMBLE_BIT = 2'd2;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET     = 32'h1000_0000;
    localparam logic             LIMIT_ENABLE_RESET   = 1'b1;
    localparam logic [2:0]       DESCRAMBLE_BIT_RESET = 3'd4;

    localparam logic [1:0] HEADER_LAST = 2'd3;   // fourth header byte
    localparam logic [2:0] KEY_LAST    = 3'd6;   // key index wraps mod 7

    typedef struct packed {
        logic [LEN_W-1:0] max_length;
        logic             limit_enable;
        logic [2:0]       descramble_bit;
    } cfg_t;

endpackage

[rtl/core/length_prefixed_frame_parser.sv]
// Top level of the length-prefixed frame parser (32-bit big-endian length).
//
// Takes one received byte per item and deframes a stream of frames, each a
// 4-byte big-endian length followed by that many body bytes. The first body
// byte is the protocol byte: it is held, not emitted. Every later body byte
// comes out as a payload result, XORed with its payload index mod 7 when the
// protocol byte has bit descramble_bit set; the final result of a frame has
// last set. A length of one gives a single empty-frame result. A zero length,
// or a length above max_length while limit_enable is set, gives one error
// result and the parser halts, swallowing bytes, until an item with
// link_reset set clears it (that item itself gives no result). The parser
// state and the result register update at the edge the item is accepted,
// and the result is offered in the next cycle. One item is accepted every
// cycle; in_ready falls only while a result sits unclaimed in
// the output register. Configuration is written over the APB port at byte
// addresses 0x0 (max_length), 0x4 (limit_enable), 0x8 (descramble_bit).
module length_prefixed_frame_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpfp_pkg::DATA_W-1:0]   pwdata,
    output logic [lpfp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lpfp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          link_reset,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpfp_pkg::BYTE_W-1:0]   out_byte,
    output logic [1:0]                    kind,
    output logic [lpfp_pkg::BYTE_W-1:0]   protocol,
    output logic                          last
);

    lpfp_pkg::cfg_t cfg;

    lpfp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser state
    logic [1:0]                   phase_reg,         phase_next;
    logic [1:0]                   header_count_reg,  header_count_next;
    logic [lpfp_pkg::LEN_W-1:0]   frame_length_reg,  frame_length_next;
    logic [lpfp_pkg::LEN_W-1:0]   bytes_left_reg,    bytes_left_next;
    logic [lpfp_pkg::BYTE_W-1:0]  held_protocol_reg, held_protocol_next;
    logic [2:0]                   key_index_reg,     key_index_next;

    // output register
    logic                         out_valid_reg,     out_valid_next;
    logic [lpfp_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [1:0]                   kind_reg;
    logic [lpfp_pkg::BYTE_W-1:0]  protocol_reg;
    logic                         last_reg;

    // result of the current item
    logic                         res_valid;
    logic [lpfp_pkg::BYTE_W-1:0]  res_byte;
    logic [1:0]                   res_kind;
    logic [lpfp_pkg::BYTE_W-1:0]  res_protocol;
    logic                         res_last;

    logic                         in_fire;
    logic [lpfp_pkg::LEN_W-1:0]   len_shift;
    logic [lpfp_pkg::LEN_W-1:0]   left_dec;
    logic                         body_done;
    logic                         descr_on;

    // Output register drains or is empty -> room for the next item.
    assign in_ready = ~out_valid_reg | out_ready;
    assign in_fire  = in_valid & in_ready;

    // Length gathers MSB first; first header byte starts from zero.
    assign len_shift = (header_count_reg == 2'd0)
                     ? {{(lpfp_pkg::LEN_W-lpfp_pkg::BYTE_W){1'b0}}, data_byte}
                     : {frame_length_reg[lpfp_pkg::LEN_W-lpfp_pkg::BYTE_W-1:0], data_byte};

    assign left_dec  = bytes_left_reg - 1'b1;
    assign body_done = (bytes_left_reg == {{(lpfp_pkg::LEN_W-1){1'b0}}, 1'b1});
    assign descr_on  = held_protocol_reg[cfg.descramble_bit];

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_length_next  = frame_length_reg;
        bytes_left_next    = bytes_left_reg;
        held_protocol_next = held_protocol_reg;
        key_index_next     = key_index_reg;

        res_valid    = 1'b0;
        res_byte     = '0;
        res_kind     = lpfp_pkg::KIND_PAYLOAD;
        res_protocol = '0;
        res_last     = 1'b0;

        if (link_reset)
        begin
            phase_next         = lpfp_pkg::PH_HEADER;
            header_count_next  = '0;
            frame_length_next  = '0;
            bytes_left_next    = '0;
            held_protocol_next = '0;
            key_index_next     = '0;
        end
        else
        begin
            case (phase_reg)
                lpfp_pkg::PH_HEADER:
                begin
                    frame_length_next = len_shift;
                    header_count_next = header_count_reg + 2'd1;
                    if (header_count_reg == lpfp_pkg::HEADER_LAST)
                    begin
                        if (len_shift == '0)
                        begin
                            phase_next = lpfp_pkg::PH_HALTED;
                            res_valid  = 1'b1;
                            res_kind   = lpfp_pkg::KIND_ZERO;
                            res_last   = 1'b1;
                        end
                        else if (cfg.limit_enable && (len_shift > cfg.max_length))
                        begin
                            phase_next = lpfp_pkg::PH_HALTED;
                            res_valid  = 1'b1;
                            res_kind   = lpfp_pkg::KIND_OVERSIZE;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = len_shift;
                            phase_next      = lpfp_pkg::PH_PROTOCOL;
                        end
                    end
                end

                lpfp_pkg::PH_PROTOCOL:
                begin
                    held_protocol_next = data_byte;
                    key_index_next     = '0;
                    bytes_left_next    = left_dec;
                    if (body_done)
                    begin
                        // frame carried only the protocol byte
                        phase_next   = lpfp_pkg::PH_HEADER;
                        res_valid    = 1'b1;
                        res_kind     = lpfp_pkg::KIND_EMPTY;
                        res_protocol = data_byte;
                        res_last     = 1'b1;
                    end
                    else
                    begin
                        phase_next = lpfp_pkg::PH_PAYLOAD;
                    end
                end

                lpfp_pkg::PH_PAYLOAD:
                begin
                    res_valid    = 1'b1;
                    res_byte     = descr_on ? (data_byte ^ {5'd0, key_index_reg}) : data_byte;
                    res_kind     = lpfp_pkg::KIND_PAYLOAD;
                    res_protocol = held_protocol_reg;
                    res_last     = body_done;
                    key_index_next  = (key_index_reg == lpfp_pkg::KEY_LAST)
                                    ? 3'd0 : key_index_reg + 3'd1;
                    bytes_left_next = left_dec;
                    if (body_done)
                    begin
                        phase_next = lpfp_pkg::PH_HEADER;
                    end
                end

                default:
                begin
                    // halted: swallow bytes until link reset
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= lpfp_pkg::PH_HEADER;
            header_count_reg  <= '0;
            frame_length_reg  <= '0;
            bytes_left_reg    <= '0;
            held_protocol_reg <= '0;
            key_index_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                header_count_reg  <= header_count_next;
                frame_length_reg  <= frame_length_next;
                bytes_left_reg    <= bytes_left_next;
                held_protocol_reg <= held_protocol_next;
                key_index_reg     <= key_index_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            out_byte_reg <= res_byte;
            kind_reg     <= res_kind;
            protocol_reg <= res_protocol;
            last_reg     <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;
    assign protocol  = protocol_reg;
    assign last      = last_reg;

endmodule

[rtl/core/lpfp_regs.sv]
// APB configuration registers of the length-prefixed frame parser.
module lpfp_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpfp_pkg::DATA_W-1:0]   pwdata,
    output logic [lpfp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output lpfp_pkg::cfg_t                cfg
);

    lpfp_pkg::cfg_t cfg_reg;
    lpfp_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                lpfp_pkg::REG_MAX_LENGTH:     cfg_next.max_length     = pwdata;
                lpfp_pkg::REG_LIMIT_ENABLE:   cfg_next.limit_enable   = pwdata[0];
                lpfp_pkg::REG_DESCRAMBLE_BIT: cfg_next.descramble_bit = pwdata[2:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length     <= lpfp_pkg::MAX_LENGTH_RESET;
            cfg_reg.limit_enable   <= lpfp_pkg::LIMIT_ENABLE_RESET;
            cfg_reg.descramble_bit <= lpfp_pkg::DESCRAMBLE_BIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            lpfp_pkg::REG_MAX_LENGTH:     prdata = cfg_reg.max_length;
            lpfp_pkg::REG_LIMIT_ENABLE:   prdata = {31'd0, cfg_reg.limit_enable};
            lpfp_pkg::REG_DESCRAMBLE_BIT: prdata = {29'd0, cfg_reg.descramble_bit};
            default:                      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
